// File: rtl/core/mab_pkg.sv
// Shared constants, register codes and types of the multi-axis low-pass filter.
// No dependencies; mab_if, mab_mac and the top level refer to this package by scoped names.
package mab_pkg;

  localparam int AXES          = 16;
  localparam int STAGES        = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int INTERNAL_BITS = 24;
  localparam int COEF_BITS     = 18;

  localparam int FRAC_BITS  = INTERNAL_BITS - SAMPLE_BITS;
  localparam int COEF_FRAC  = COEF_BITS - 3;
  localparam int ALPHA_FRAC = COEF_BITS - 1;
  localparam int MAX_ORDER  = 8;

  localparam int AXIS_BITS     = 4;
  localparam int ORDER_BITS    = 4;
  localparam int AXES_CFG_BITS = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 3 * COEF_BITS;
  localparam int STAGE_BITS    = $clog2(STAGES);
  localparam int IDX_BITS      = $clog2(AXES * STAGES);

  // Shared multiplier operands: signed coefficient / gain and a widened data word.
  localparam int OPA_BITS  = COEF_BITS + 1;
  localparam int OPB_BITS  = INTERNAL_BITS + 2;
  localparam int PROD_BITS = OPA_BITS + OPB_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE0 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE2 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE3 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXES   = 3'd6;

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  typedef struct packed {
    logic       prod_en;
    logic [1:0] acc_op;
    logic       alpha_shift;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [INTERNAL_BITS-1:0] in_last;
    logic signed [INTERNAL_BITS-1:0] in_older;
    logic signed [INTERNAL_BITS-1:0] out_last;
    logic signed [INTERNAL_BITS-1:0] out_older;
  } stage_state_t;

endpackage

// File: rtl/core/mab_if.sv
// Valid/ready channel interfaces: sample requests, result requests, register writes.
// Depends on mab_pkg for field widths.
interface mab_in_if ();
  logic                                   valid;
  logic                                   ready;
  logic [mab_pkg::AXIS_BITS-1:0]          axis;
  logic signed [mab_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, axis, sample_in, input ready);
  modport sink (input valid, axis, sample_in, output ready);
endinterface

interface mab_out_if ();
  logic                                   valid;
  logic                                   ready;
  logic [mab_pkg::AXIS_BITS-1:0]          axis_out;
  logic signed [mab_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   axis_error;

  modport source (output valid, axis_out, sample_out, axis_error, input ready);
  modport sink (input valid, axis_out, sample_out, axis_error, output ready);
endinterface

interface mab_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [mab_pkg::CFG_IDX_BITS-1:0]   index;
  logic [mab_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/mab_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/mab_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation to the internal width.
// Depends on mab_pkg (widths, accumulator codes, mac_ctrl_t).
module mab_mac (
  input  logic                                     clk,
  input  mab_pkg::mac_ctrl_t                       ctrl,
  input  logic signed [mab_pkg::OPA_BITS-1:0]      opa,
  input  logic signed [mab_pkg::OPB_BITS-1:0]      opb,
  output logic signed [mab_pkg::INTERNAL_BITS-1:0] result
);

  localparam int AW = mab_pkg::ACC_BITS;
  localparam int IW = mab_pkg::INTERNAL_BITS;
  localparam logic signed [AW-1:0] HALF_A = AW'(64'sd1 <<< (mab_pkg::ALPHA_FRAC - 1));
  localparam logic signed [AW-1:0] HALF_C = AW'(64'sd1 <<< (mab_pkg::COEF_FRAC - 1));
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (IW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO = AW'(-(64'sd1 <<< (IW - 1)));

  logic signed [mab_pkg::PROD_BITS-1:0] prod_r;
  logic signed [AW-1:0]                 acc_r;
  logic signed [AW-1:0]                 acc_rnd;
  logic signed [AW-1:0]                 acc_sh;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod_r <= opa * opb;
    end
    case (ctrl.acc_op)
      mab_pkg::ACC_LOAD: acc_r <= AW'(prod_r);
      mab_pkg::ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      default:           acc_r <= acc_r;
    endcase
  end

  // Round to nearest with ties up, then clamp to the internal range.
  always_comb begin
    acc_rnd = acc_r + (ctrl.alpha_shift ? HALF_A : HALF_C);
    acc_sh  = ctrl.alpha_shift ? (acc_rnd >>> mab_pkg::ALPHA_FRAC)
                               : (acc_rnd >>> mab_pkg::COEF_FRAC);
    if (acc_sh > SAT_HI) begin
      result = SAT_HI[IW-1:0];
    end else if (acc_sh < SAT_LO) begin
      result = SAT_LO[IW-1:0];
    end else begin
      result = acc_sh[IW-1:0];
    end
  end

endmodule

// File: rtl/core/multi_axis_butterworth_lowpass.sv
// Top level of the multi-axis Butterworth low-pass filter: sequencer, registers, state.
// Depends on mab_pkg, mab_if (channel interfaces), mab_mac and mab_ram.
//
// Usage
//   in_chan   : one sample request per item (axis, sample_in). Accepted when valid and
//               ready are high at a rising edge; ready is high only while the sequencer
//               is idle.
//   out_chan  : one result request per item (axis_out, sample_out, axis_error), held in
//               an output register until the receiver takes it. A new sample is accepted
//               while a result still waits; the next result waits in the sequencer until
//               the output register is free, so a stalled receiver stalls the input.
//   cfg_chan  : register writes (index, data), always ready. Write only while idle.
//               Writing filter_order clears all per-axis history at once.
// Timing
//   Every product goes through one shared multiplier. An item occupies the sequencer
//   for a first-order step when order bit 0 is set, then n = order/2 biquads; bypass
//   or a bad axis skips both. Per biquad: a history read from the state RAM, a load,
//   three products, one final add and a write-back. Result valid is registered as the
//   sequencer leaves its done state.
// Reset
//   rst_n is synchronous, active low. Registers take their reset values, the first-order
//   history clears and every biquad history entry is marked empty (reads as zero).
module multi_axis_butterworth_lowpass (
  input  logic     clk,
  input  logic     rst_n,
  mab_in_if.sink   in_chan,
  mab_out_if.source out_chan,
  mab_cfg_if.sink  cfg_chan
);

  localparam int IW   = mab_pkg::INTERNAL_BITS;
  localparam int SW   = mab_pkg::SAMPLE_BITS;
  localparam int BW   = mab_pkg::OPB_BITS;
  localparam int CW   = mab_pkg::COEF_BITS;
  localparam int XW   = mab_pkg::IDX_BITS;
  localparam int KW   = mab_pkg::STAGE_BITS;
  localparam int NW   = mab_pkg::ORDER_BITS - 1;
  localparam int RW   = IW + 1;
  localparam int DEPTH = mab_pkg::AXES * mab_pkg::STAGES;

  localparam logic [CW-1:0] ALPHA_ONE = CW'(1) << mab_pkg::ALPHA_FRAC;
  localparam logic [mab_pkg::ORDER_BITS-1:0] ORDER_MAX = mab_pkg::ORDER_BITS'(mab_pkg::MAX_ORDER);
  localparam logic signed [RW-1:0] OUT_HALF = RW'(64'sd1 <<< (mab_pkg::FRAC_BITS - 1));
  localparam logic signed [RW-1:0] OUT_HI = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] OUT_LO = RW'(-(64'sd1 <<< (SW - 1)));

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FO_M0  = 4'd1;
  localparam logic [3:0] ST_FO_M1  = 4'd2;
  localparam logic [3:0] ST_FO_ACC = 4'd3;
  localparam logic [3:0] ST_FO_WB  = 4'd4;
  localparam logic [3:0] ST_BQ_RD  = 4'd5;
  localparam logic [3:0] ST_BQ_LD  = 4'd6;
  localparam logic [3:0] ST_BQ_M0  = 4'd7;
  localparam logic [3:0] ST_BQ_M1  = 4'd8;
  localparam logic [3:0] ST_BQ_M2  = 4'd9;
  localparam logic [3:0] ST_BQ_ACC = 4'd10;
  localparam logic [3:0] ST_BQ_WB  = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  // Configuration registers.
  logic [mab_pkg::ORDER_BITS-1:0]    order_r;
  logic [CW-1:0]                     gain_r;
  logic [mab_pkg::CFG_DATA_BITS-1:0] coefs_r [mab_pkg::STAGES];
  logic [mab_pkg::AXES_CFG_BITS-1:0] axes_r;

  // Sequencer and datapath registers.
  logic [3:0]                    state_r, state_nxt;
  logic [mab_pkg::AXIS_BITS-1:0] axis_r;
  logic [KW-1:0]                 k_r;
  logic signed [IW-1:0]          x_r, xl_r, yl_r, yo_r;
  logic signed [BW-1:0]          num_r;
  logic signed [SW-1:0]          res_r;
  logic                          err_r;

  logic                          out_valid_r;
  logic [mab_pkg::AXIS_BITS-1:0] out_axis_r;
  logic signed [SW-1:0]          out_sample_r;
  logic                          out_err_r;

  // Per-axis state.
  logic signed [IW-1:0] smooth_r [mab_pkg::AXES];
  logic [DEPTH-1:0]     vld_r;

  // Combinational helpers.
  logic                          in_fire, cfg_fire, out_fire, out_free;
  logic                          axis_bad;
  logic [NW-1:0]                 nstages;
  logic [CW-1:0]                 alpha_c;
  logic [mab_pkg::CFG_DATA_BITS-1:0] coef_sel;
  logic [XW-1:0]                 idx;
  mab_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [mab_pkg::OPA_BITS-1:0] mac_opa;
  logic signed [BW-1:0]          mac_opb;
  logic signed [IW-1:0]          mac_res;
  logic [$bits(mab_pkg::stage_state_t)-1:0] ram_rd_data;
  mab_pkg::stage_state_t         st_q, st_sel, st_wr;
  logic                          ram_wr_en, ram_rd_en;
  logic signed [BW-1:0]          num_nxt;
  logic signed [RW-1:0]          fin_sum, fin_sh;
  logic signed [SW-1:0]          fin_val;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign cfg_chan.ready  = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.axis_out   = out_axis_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.axis_error = out_err_r;

  assign axis_bad = ({1'b0, in_chan.axis} >= axes_r) ||
                    ({1'b0, in_chan.axis} >= mab_pkg::AXES_CFG_BITS'(mab_pkg::AXES));
  assign nstages  = order_r[mab_pkg::ORDER_BITS-1:1];
  assign alpha_c  = (gain_r > ALPHA_ONE) ? ALPHA_ONE : gain_r;
  assign coef_sel = coefs_r[k_r];
  assign idx      = XW'(XW'(axis_r) * XW'(mab_pkg::STAGES) + XW'(k_r));

  // An empty history entry reads as zero.
  assign st_q    = mab_pkg::stage_state_t'(ram_rd_data);
  assign st_sel  = vld_r[idx] ? st_q : '0;
  assign num_nxt = BW'(x_r) + (BW'(st_sel.in_last) <<< 1) + BW'(st_sel.in_older);

  assign st_wr.in_last   = x_r;
  assign st_wr.in_older  = xl_r;
  assign st_wr.out_last  = mac_res;
  assign st_wr.out_older = yl_r;
  assign ram_wr_en = (state_r == ST_BQ_WB);
  assign ram_rd_en = (state_r == ST_BQ_RD);

  // Final Q16.8 to integer rounding with saturation.
  assign fin_sum = RW'(x_r) + OUT_HALF;
  assign fin_sh  = fin_sum >>> mab_pkg::FRAC_BITS;
  assign fin_val = (fin_sh > OUT_HI) ? OUT_HI[SW-1:0] :
                   (fin_sh < OUT_LO) ? OUT_LO[SW-1:0] : fin_sh[SW-1:0];

  // Sequencer: next state and shared-unit control.
  always_comb begin
    state_nxt = state_r;
    mac_ctrl  = '{prod_en: 1'b0, acc_op: mab_pkg::ACC_HOLD, alpha_shift: 1'b0};
    mac_opa   = '0;
    mac_opb   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (axis_bad || (order_r == '0)) begin
            state_nxt = ST_DONE;
          end else if (order_r[0]) begin
            state_nxt = ST_FO_M0;
          end else begin
            state_nxt = ST_BQ_RD;
          end
        end
      end
      ST_FO_M0: begin
        mac_ctrl.prod_en = 1'b1;
        mac_opa   = $signed({1'b0, alpha_c});
        mac_opb   = BW'(smooth_r[axis_r]);
        state_nxt = ST_FO_M1;
      end
      ST_FO_M1: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_op  = mab_pkg::ACC_LOAD;
        mac_opa   = $signed({1'b0, ALPHA_ONE - alpha_c});
        mac_opb   = BW'(x_r);
        state_nxt = ST_FO_ACC;
      end
      ST_FO_ACC: begin
        mac_ctrl.acc_op = mab_pkg::ACC_ADD;
        state_nxt = ST_FO_WB;
      end
      ST_FO_WB: begin
        mac_ctrl.alpha_shift = 1'b1;
        state_nxt = (nstages == '0) ? ST_FIN : ST_BQ_RD;
      end
      ST_BQ_RD: state_nxt = ST_BQ_LD;
      ST_BQ_LD: state_nxt = ST_BQ_M0;
      ST_BQ_M0: begin
        mac_ctrl.prod_en = 1'b1;
        mac_opa   = mab_pkg::OPA_BITS'($signed(coef_sel[CW-1:0]));
        mac_opb   = num_r;
        state_nxt = ST_BQ_M1;
      end
      ST_BQ_M1: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_op  = mab_pkg::ACC_LOAD;
        mac_opa   = mab_pkg::OPA_BITS'($signed(coef_sel[2*CW-1:CW]));
        mac_opb   = BW'(yl_r);
        state_nxt = ST_BQ_M2;
      end
      ST_BQ_M2: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_op  = mab_pkg::ACC_ADD;
        mac_opa   = mab_pkg::OPA_BITS'($signed(coef_sel[3*CW-1:2*CW]));
        mac_opb   = BW'(yo_r);
        state_nxt = ST_BQ_ACC;
      end
      ST_BQ_ACC: begin
        mac_ctrl.acc_op = mab_pkg::ACC_ADD;
        state_nxt = ST_BQ_WB;
      end
      ST_BQ_WB: begin
        state_nxt = (NW'(k_r) + NW'(1) == nstages) ? ST_FIN : ST_BQ_RD;
      end
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and per-axis history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      order_r     <= '0;
      gain_r      <= '0;
      axes_r      <= mab_pkg::AXES_CFG_BITS'(16);
      vld_r       <= '0;
      for (int i = 0; i < mab_pkg::STAGES; i++) begin
        coefs_r[i] <= '0;
      end
      for (int i = 0; i < mab_pkg::AXES; i++) begin
        smooth_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Hold the result until taken; load a new one when the slot frees.
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_FO_WB) begin
        smooth_r[axis_r] <= mac_res;
      end
      if (state_r == ST_BQ_WB) begin
        vld_r[idx] <= 1'b1;
      end

      if (cfg_fire) begin
        unique case (cfg_chan.index) inside
          mab_pkg::REG_ORDER: begin
            order_r <= (cfg_chan.data[mab_pkg::ORDER_BITS-1:0] > ORDER_MAX) ?
                       ORDER_MAX : cfg_chan.data[mab_pkg::ORDER_BITS-1:0];
            // Drop all history.
            vld_r <= '0;
            for (int i = 0; i < mab_pkg::AXES; i++) begin
              smooth_r[i] <= '0;
            end
          end
          mab_pkg::REG_GAIN: gain_r <= cfg_chan.data[CW-1:0];
          mab_pkg::REG_STAGE0, mab_pkg::REG_STAGE1,
          mab_pkg::REG_STAGE2, mab_pkg::REG_STAGE3: begin
            coefs_r[KW'(cfg_chan.index - mab_pkg::REG_STAGE0)] <= cfg_chan.data;
          end
          mab_pkg::REG_AXES: axes_r <= cfg_chan.data[mab_pkg::AXES_CFG_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          axis_r <= in_chan.axis;
          k_r    <= '0;
          x_r    <= IW'(in_chan.sample_in) <<< mab_pkg::FRAC_BITS;
          res_r  <= in_chan.sample_in;
          err_r  <= axis_bad;
        end
      end
      ST_FO_WB: x_r <= mac_res;
      ST_BQ_LD: begin
        xl_r  <= st_sel.in_last;
        yl_r  <= st_sel.out_last;
        yo_r  <= st_sel.out_older;
        num_r <= num_nxt;
      end
      ST_BQ_WB: begin
        x_r <= mac_res;
        k_r <= k_r + KW'(1);
      end
      ST_FIN: res_r <= fin_val;
      ST_DONE: begin
        if (out_free) begin
          out_axis_r   <= axis_r;
          out_sample_r <= res_r;
          out_err_r    <= err_r;
        end
      end
      default: ;
    endcase
  end

  mab_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .opa    (mac_opa),
    .opb    (mac_opb),
    .result (mac_res)
  );

  mab_ram #(
    .WIDTH ($bits(mab_pkg::stage_state_t)),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx),
    .wr_data (st_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (idx),
    .rd_data (ram_rd_data)
  );

  // An accepted request always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_chan.ready)
    else $error("input still ready after accepting a request");

  // A finished result waits in the sequencer while the output register is full.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_chan.ready |=> (state_r == ST_DONE))
    else $error("result left the sequencer while output stalled");

  // The stage counter stays inside the configured cascade.
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BQ_RD) |-> (NW'(k_r) < nstages))
    else $error("biquad stage beyond configured order");

endmodule
